// ----- rtl/dhti_pkg.sv -----
// Shared types and constants of the degree-hour table interpolator.
`timescale 1ns / 1ps
`default_nettype none

package dhti_pkg;

  localparam int unsigned TEMP_W = 16;
  localparam int unsigned DH_W = 24;
  localparam int unsigned OUT_W = 16;
  localparam int unsigned DAYS_W = 5;
  localparam int unsigned DIVR_W = 9;
  localparam int unsigned PROD_W = 40;

  localparam int unsigned DIV_QW = 24;
  localparam int unsigned DIV_DW = 16;

  localparam logic [DIVR_W-1:0] HOURS_PER_HALF_DAY = 9'd12;
  localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [TEMP_W-1:0] base;
    logic [DH_W-1:0]   day_dh;
    logic [DH_W-1:0]   night_dh;
  } entry_t;

  typedef struct packed {
    logic ld_first;
    logic ld_last;
    logic ld_scan;
    logic calc;
  } chan_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/degree_hour_table_interpolator.sv -----
// Top level of the degree-hour table interpolator.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// command   in         start_i, busy_o           operation_i, entry_*_i, balance_*_i,
//                                                days_in_period_i
// result    out        result_valid_o (strobe)   avg_day_deg_hours_o,
//                                                avg_night_deg_hours_o, error_o
//
// A command transfer happens on a rising edge with start_i high and busy_o low.
// A table write completes in its own transfer cycle and leaves busy_o low.
// A query with a zero day count returns its error result in the next cycle.
// Any other query streams the table through the single memory read port, then
// each channel forms the product and makes two divider runs, with hand-over
// states around them. Reset is asynchronous and active low; the table contents
// are not cleared by it. The result strobe lasts exactly one cycle and cannot be
// held off by the receiver.

module degree_hour_table_interpolator #(
  parameter int unsigned NUM_BINS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        operation_i,
  input  wire logic [2:0]  entry_index_i,
  input  wire logic [15:0] entry_base_temp_i,
  input  wire logic [23:0] entry_day_dh_i,
  input  wire logic [23:0] entry_night_dh_i,
  input  wire logic [15:0] balance_day_temp_i,
  input  wire logic [15:0] balance_night_temp_i,
  input  wire logic [4:0]  days_in_period_i,
  output logic             result_valid_o,
  output logic [15:0]      avg_day_deg_hours_o,
  output logic [15:0]      avg_night_deg_hours_o,
  output logic             error_o
);

  localparam int unsigned IDX_W = $clog2(NUM_BINS);
  localparam int unsigned STEP_W = $clog2(NUM_BINS + 2);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [15:0]       tday_q, tnight_q;
  logic [dhti_pkg::DIVR_W-1:0] divisor_q;
  logic              dflag_q, nflag_q;
  logic              valid_q;
  logic [15:0]       avg_day_q, avg_night_q;
  logic              err_q;

  logic              accept;
  logic              do_write, do_query, zero_days;
  logic [6:0]        widx;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [STEP_W-1:0] step_m1;
  logic              scan_end, calc_end;
  dhti_pkg::entry_t  wdata, rdata;
  dhti_pkg::chan_ctl_t ctl;
  logic              day_done, night_done;
  logic [15:0]       day_res, night_res;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // Writes beyond the table are dropped; the table is only written while idle,
  // so scan reads never meet a write to the same bin.
  assign widx      = 7'(entry_index_i);
  assign waddr     = widx[IDX_W-1:0];
  assign do_write  = accept && (operation_i == dhti_pkg::OP_WRITE)
                     && (32'(entry_index_i) < 32'(NUM_BINS));
  assign do_query  = accept && (operation_i == dhti_pkg::OP_QUERY);
  assign zero_days = (days_in_period_i == '0);

  always_comb begin
    wdata.base     = entry_base_temp_i;
    wdata.day_dh   = entry_day_dh_i;
    wdata.night_dh = entry_night_dh_i;
  end

  // Read order: first bin, last bin, then bins one upward to the last. Each
  // read's data arrives in the next cycle and is tagged by the step count.
  assign step_m1 = step_q - STEP_W'(1);
  always_comb begin
    if (step_q == '0) begin
      raddr = '0;
    end else if (step_q == STEP_W'(1)) begin
      raddr = IDX_W'(NUM_BINS - 1);
    end else begin
      raddr = step_m1[IDX_W-1:0];
    end
  end

  assign scan_end = (state_q == S_SCAN) && (step_q == STEP_W'(NUM_BINS + 1));

  always_comb begin
    ctl.ld_first = (state_q == S_SCAN) && (step_q == STEP_W'(1));
    ctl.ld_last  = (state_q == S_SCAN) && (step_q == STEP_W'(2));
    ctl.ld_scan  = (state_q == S_SCAN) && (step_q >= STEP_W'(3));
    ctl.calc     = scan_end;
  end

  // Both channels run the same schedule, so both done strobes arrive together.
  assign calc_end = (state_q == S_CALC) && (day_done || dflag_q) && (night_done || nflag_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (do_query && !zero_days) state_d = S_SCAN;
      S_SCAN: if (scan_end) state_d = S_CALC;
      S_CALC: if (calc_end) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      dflag_q <= 1'b0;
      nflag_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (do_query && zero_days) || calc_end;
      if (state_q == S_SCAN) begin
        step_q <= step_q + STEP_W'(1);
      end else begin
        step_q <= '0;
      end
      if (calc_end) begin
        dflag_q <= 1'b0;
        nflag_q <= 1'b0;
      end else begin
        if (day_done) dflag_q <= 1'b1;
        if (night_done) nflag_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_query) begin
      tday_q    <= balance_day_temp_i;
      tnight_q  <= balance_night_temp_i;
      divisor_q <= dhti_pkg::DIVR_W'(days_in_period_i) * dhti_pkg::HOURS_PER_HALF_DAY;
    end
    if (do_query && zero_days) begin
      avg_day_q   <= '0;
      avg_night_q <= '0;
      err_q       <= 1'b1;
    end else if (calc_end) begin
      avg_day_q   <= day_res;
      avg_night_q <= night_res;
      err_q       <= 1'b0;
    end
  end

  dhti_table #(
    .NUM_BINS (NUM_BINS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dhti_chan u_day (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .temp_i    (tday_q),
    .base_i    (rdata.base),
    .dh_i      (rdata.day_dh),
    .ctl_i     (ctl),
    .divisor_i (divisor_q),
    .done_o    (day_done),
    .result_o  (day_res)
  );

  dhti_chan u_night (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .temp_i    (tnight_q),
    .base_i    (rdata.base),
    .dh_i      (rdata.night_dh),
    .ctl_i     (ctl),
    .divisor_i (divisor_q),
    .done_o    (night_done),
    .result_o  (night_res)
  );

  assign result_valid_o        = valid_q;
  assign avg_day_deg_hours_o   = avg_day_q;
  assign avg_night_deg_hours_o = avg_night_q;
  assign error_o               = err_q;

endmodule

`default_nettype wire

// ----- rtl/dhti_table.sv -----
// Bin table memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dhti_table #(
  parameter int unsigned NUM_BINS = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [$clog2(NUM_BINS)-1:0] waddr_i,
  input  wire dhti_pkg::entry_t            wdata_i,
  input  wire logic [$clog2(NUM_BINS)-1:0] raddr_i,
  output dhti_pkg::entry_t                 rdata_o
);

  dhti_pkg::entry_t mem_q [NUM_BINS];
  dhti_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/dhti_div.sv -----
// Iterative restoring divider that retires two quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dhti_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [dhti_pkg::DIV_DW-1:0]   rem_i,
  input  wire logic [dhti_pkg::DIV_QW-1:0]   num_i,
  input  wire logic [dhti_pkg::DIV_DW-1:0]   den_i,
  output logic                               done_o,
  output logic [dhti_pkg::DIV_QW-1:0]        quo_o
);

  localparam int unsigned DW = dhti_pkg::DIV_DW;
  localparam int unsigned QW = dhti_pkg::DIV_QW;
  localparam int unsigned CNT_W = $clog2(QW / 2 + 1);

  logic [DW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  logic [DW:0]      r1, r2;
  logic             ge1, ge2;
  logic [DW-1:0]    n1;
  logic [DW:0]      n2;

  // Two dependent compare-and-subtract steps; the remainder stays below the divisor.
  always_comb begin
    r1 = {rem_q, quo_q[QW-1]};
    ge1 = (r1 >= {1'b0, den_q});
    n1 = ge1 ? DW'(r1 - {1'b0, den_q}) : r1[DW-1:0];
    r2 = {n1, quo_q[QW-2]};
    ge2 = (r2 >= {1'b0, den_q});
    n2 = ge2 ? (r2 - {1'b0, den_q}) : r2;
    rem_d = n2[DW-1:0];
    quo_d = {quo_q[QW-3:0], ge1, ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(QW / 2);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ----- rtl/dhti_chan.sv -----
// One channel: bin match during the table scan, interpolation and scaling.
`timescale 1ns / 1ps
`default_nettype none

module dhti_chan (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [dhti_pkg::TEMP_W-1:0]   temp_i,
  input  wire logic [dhti_pkg::TEMP_W-1:0]   base_i,
  input  wire logic [dhti_pkg::DH_W-1:0]     dh_i,
  input  wire dhti_pkg::chan_ctl_t           ctl_i,
  input  wire logic [dhti_pkg::DIVR_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic [dhti_pkg::OUT_W-1:0]         result_o
);

  localparam int unsigned TW = dhti_pkg::TEMP_W;
  localparam int unsigned DHW = dhti_pkg::DH_W;
  localparam int unsigned PW = dhti_pkg::PROD_W;
  localparam int unsigned DW = dhti_pkg::DIV_DW;
  localparam int unsigned QW = dhti_pkg::DIV_QW;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_MUL  = 3'd1;
  localparam logic [2:0] C_D1GO = 3'd2;
  localparam logic [2:0] C_D1WT = 3'd3;
  localparam logic [2:0] C_D2GO = 3'd4;
  localparam logic [2:0] C_D2WT = 3'd5;

  logic [2:0]     state_q, state_d;
  logic           found_q;
  logic           done_q;
  logic [TW-1:0]  prev_b_q;
  logic [DHW-1:0] prev_d_q;
  logic [DHW-1:0] d0_q;
  logic [DHW-1:0] mag_q;
  logic           neg_q;
  logic [TW-1:0]  tb_q;
  logic [TW-1:0]  den_q;
  logic [PW-1:0]  prod_q;
  logic [DHW-1:0] total_q;
  logic [dhti_pkg::OUT_W-1:0] res_q;

  logic           t_le_base, t_ge_base, in_bin;
  logic [DHW:0]   diff;
  logic [DHW:0]   diff_abs;
  logic [TW:0]    tb_full, den_full;

  logic           div_start, div_done;
  logic [DW-1:0]  div_rem, div_den;
  logic [QW-1:0]  div_num, div_quo;

  always_comb begin
    t_le_base = ($signed(temp_i) <= $signed(base_i));
    t_ge_base = ($signed(temp_i) >= $signed(base_i));
    in_bin    = ($signed(temp_i) > $signed(prev_b_q)) && t_le_base;
    diff      = {1'b0, dh_i} - {1'b0, prev_d_q};
    diff_abs  = diff[DHW] ? ((DHW+1)'(0) - diff) : diff;
    tb_full   = {temp_i[TW-1], temp_i} - {prev_b_q[TW-1], prev_b_q};
    den_full  = {base_i[TW-1], base_i} - {prev_b_q[TW-1], prev_b_q};
  end

  // Capture of the interpolation points while the table streams past.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.ld_first) begin
      found_q <= t_le_base;
    end else if (ctl_i.ld_last && !found_q && t_ge_base) begin
      found_q <= 1'b1;
    end else if (ctl_i.ld_scan && !found_q && in_bin) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_first) begin
      prev_b_q <= base_i;
      prev_d_q <= dh_i;
      d0_q     <= t_le_base ? dh_i : '0;
      mag_q    <= '0;
      neg_q    <= 1'b0;
      tb_q     <= '0;
      den_q    <= TW'(1);
    end else if (ctl_i.ld_last) begin
      if (!found_q && t_ge_base) begin
        d0_q <= dh_i;
      end
    end else if (ctl_i.ld_scan) begin
      prev_b_q <= base_i;
      prev_d_q <= dh_i;
      if (!found_q && in_bin) begin
        d0_q  <= prev_d_q;
        mag_q <= diff_abs[DHW-1:0];
        neg_q <= diff[DHW];
        tb_q  <= tb_full[TW-1:0];
        den_q <= den_full[TW-1:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE: if (ctl_i.calc) state_d = C_MUL;
      C_MUL:  state_d = C_D1GO;
      C_D1GO: state_d = C_D1WT;
      C_D1WT: if (div_done) state_d = C_D2GO;
      C_D2GO: state_d = C_D2WT;
      C_D2WT: if (div_done) state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == C_D2WT) && div_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == C_MUL) begin
      prod_q <= PW'(mag_q) * PW'(tb_q);
    end
    if (state_q == C_D1WT && div_done) begin
      total_q <= neg_q ? (d0_q - div_quo) : (d0_q + div_quo);
    end
    if (state_q == C_D2WT && div_done) begin
      res_q <= (div_quo[QW-1:dhti_pkg::OUT_W] != '0) ? dhti_pkg::OUT_MAX
                                                     : div_quo[dhti_pkg::OUT_W-1:0];
    end
  end

  // The product over the bin width is below 2^24, so its upper bits start as remainder.
  always_comb begin
    div_start = (state_q == C_D1GO) || (state_q == C_D2GO);
    if (state_q == C_D2GO) begin
      div_rem = '0;
      div_num = total_q;
      div_den = DW'(divisor_i);
    end else begin
      div_rem = prod_q[PW-1:QW];
      div_num = prod_q[QW-1:0];
      div_den = den_q;
    end
  end

  dhti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the degree-hour table interpolator: table loads and queries.
`timescale 1ns / 1ps

module tb_top;
  import dhti_pkg::*;

  localparam int TABLE_BINS = 8;
  // Table scan, product and the two divider runs of each channel.
  localparam int QUERY_LATENCY = TABLE_BINS + 32;

  typedef enum int {LOAD_SORTED, LOAD_NARROW, LOAD_UNSORTED} load_kind_e;

  // One command as it crosses the command channel.
  typedef struct packed {
    logic              op;
    logic [2:0]        idx;
    logic [TEMP_W-1:0] base;
    logic [DH_W-1:0]   day_dh;
    logic [DH_W-1:0]   night_dh;
    logic [TEMP_W-1:0] t_day;
    logic [TEMP_W-1:0] t_night;
    logic [DAYS_W-1:0] days;
  } dh_cmd_t;

  // Averages that one query is expected to return.
  typedef struct packed {
    logic [OUT_W-1:0] day_avg;
    logic [OUT_W-1:0] night_avg;
    logic             err;
  } dh_avg_t;

  logic              clk_i                = 1'b0;
  logic              rst_ni               = 1'b0;
  logic              start_i              = 1'b0;
  logic              busy_o;
  logic              operation_i          = OP_WRITE;
  logic [2:0]        entry_index_i        = '0;
  logic [TEMP_W-1:0] entry_base_temp_i    = '0;
  logic [DH_W-1:0]   entry_day_dh_i       = '0;
  logic [DH_W-1:0]   entry_night_dh_i     = '0;
  logic [TEMP_W-1:0] balance_day_temp_i   = '0;
  logic [TEMP_W-1:0] balance_night_temp_i = '0;
  logic [DAYS_W-1:0] days_in_period_i     = '0;
  logic              result_valid_o;
  logic [OUT_W-1:0]  avg_day_deg_hours_o;
  logic [OUT_W-1:0]  avg_night_deg_hours_o;
  logic              error_o;

  // Shadow copy of the bin table and the averages still to come back.
  entry_t  dh_table [TABLE_BINS];
  dh_avg_t pending_averages [$];

  int sender_idle_pct = 0;
  int cmds_sent       = 0;
  int n_writes        = 0;
  int n_queries       = 0;
  int n_zero_day      = 0;
  int n_saturated     = 0;
  int n_loads         = 0;
  int n_unsorted      = 0;
  int n_mismatches    = 0;

  degree_hour_table_interpolator #(
    .NUM_BINS(TABLE_BINS)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .operation_i          (operation_i),
    .entry_index_i        (entry_index_i),
    .entry_base_temp_i    (entry_base_temp_i),
    .entry_day_dh_i       (entry_day_dh_i),
    .entry_night_dh_i     (entry_night_dh_i),
    .balance_day_temp_i   (balance_day_temp_i),
    .balance_night_temp_i (balance_night_temp_i),
    .days_in_period_i     (days_in_period_i),
    .result_valid_o       (result_valid_o),
    .avg_day_deg_hours_o  (avg_day_deg_hours_o),
    .avg_night_deg_hours_o(avg_night_deg_hours_o),
    .error_o              (error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint bin_base(input int i);
    return longint'($signed(dh_table[i].base));
  endfunction

  function automatic longint bin_total(input bit is_day, input int i);
    return is_day ? longint'(dh_table[i].day_dh) : longint'(dh_table[i].night_dh);
  endfunction

  // Degree-hour total for one balance temperature: clamp at either end of the
  // table, otherwise interpolate inside the first bin whose upper base reaches it.
  function automatic longint interp_channel_total(input bit is_day,
                                                  input logic [TEMP_W-1:0] t_raw);
    longint t;
    longint b0;
    longint b1;
    longint total;
    bit     found;
    t = longint'($signed(t_raw));
    if (t <= bin_base(0)) return bin_total(is_day, 0);
    if (t >= bin_base(TABLE_BINS - 1)) return bin_total(is_day, TABLE_BINS - 1);
    total = 0;
    found = 1'b0;
    for (int i = 0; i < TABLE_BINS - 1; i++) begin
      b0 = bin_base(i);
      b1 = bin_base(i + 1);
      if (!found && t > b0 && t <= b1) begin
        // Signed division truncates toward zero, also for a falling total.
        total = bin_total(is_day, i) +
                (bin_total(is_day, i + 1) - bin_total(is_day, i)) * (t - b0) / (b1 - b0);
        found = 1'b1;
      end
    end
    return total;
  endfunction

  function automatic logic [OUT_W-1:0] avg_per_half_day(input longint total,
                                                        input logic [DAYS_W-1:0] days);
    longint q;
    q = total / (longint'(days) * longint'(HOURS_PER_HALF_DAY));
    if (q > longint'(OUT_MAX)) q = longint'(OUT_MAX);
    return q[OUT_W-1:0];
  endfunction

  function automatic int rand_base();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int unsigned rand_dh();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 24'hFFFFFF;
    if (r < 6) return $urandom_range(1 << 18);
    return $urandom_range(24'hFFFFFF);
  endfunction

  function automatic int rand_days();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 0;
    if (r < 18) return $urandom_range(1) ? 31 : 1;
    return $urandom_range(1, 31);
  endfunction

  // Balance temperatures mostly land on, beside or between the stored bases.
  function automatic int pick_temp();
    int r;
    int i;
    int lo;
    int hi;
    int v;
    r = $urandom_range(99);
    i = $urandom_range(TABLE_BINS - 2);
    if (r < 40) begin
      v = int'(bin_base(i + $urandom_range(1))) + int'($urandom_range(2)) - 1;
    end else if (r < 70) begin
      lo = int'(bin_base(i));
      hi = int'(bin_base(i + 1));
      if (lo > hi) begin
        v  = lo;
        lo = hi;
        hi = v;
      end
      v = lo + int'($urandom_range(hi - lo));
    end else if (r < 90) begin
      v = rand_base();
    end else begin
      v = $urandom_range(1) ? 32767 : -32768;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Every field random, so that unused fields also toggle on each transfer.
  function automatic dh_cmd_t rand_cmd();
    dh_cmd_t c;
    c.op       = 1'($urandom_range(1));
    c.idx      = 3'($urandom_range(7));
    c.base     = 16'($urandom_range(16'hFFFF));
    c.day_dh   = 24'($urandom_range(24'hFFFFFF));
    c.night_dh = 24'($urandom_range(24'hFFFFFF));
    c.t_day    = 16'($urandom_range(16'hFFFF));
    c.t_night  = 16'($urandom_range(16'hFFFF));
    c.days     = 5'($urandom_range(31));
    return c;
  endfunction

  // Drives one command and holds it until busy_o is low at a rising edge,
  // which is the transfer. Called just after a rising edge; start_i is left
  // high so that the next command can follow without a gap.
  task automatic send_cmd(input dh_cmd_t c);
    int      gap;
    dh_avg_t want;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 45);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i              <= 1'b1;
    operation_i          <= c.op;
    entry_index_i        <= c.idx;
    entry_base_temp_i    <= c.base;
    entry_day_dh_i       <= c.day_dh;
    entry_night_dh_i     <= c.night_dh;
    balance_day_temp_i   <= c.t_day;
    balance_night_temp_i <= c.t_night;
    days_in_period_i     <= c.days;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    if (c.op == OP_WRITE) begin
      // The index field cannot exceed the bin count here, so every write lands.
      dh_table[c.idx].base     = c.base;
      dh_table[c.idx].day_dh   = c.day_dh;
      dh_table[c.idx].night_dh = c.night_dh;
      n_writes++;
    end else begin
      if (c.days == '0) begin
        want.day_avg   = '0;
        want.night_avg = '0;
        want.err       = 1'b1;
        n_zero_day++;
      end else begin
        want.day_avg   = avg_per_half_day(interp_channel_total(1'b1, c.t_day), c.days);
        want.night_avg = avg_per_half_day(interp_channel_total(1'b0, c.t_night), c.days);
        want.err       = 1'b0;
        if (want.day_avg == OUT_MAX || want.night_avg == OUT_MAX) n_saturated++;
      end
      pending_averages.push_back(want);
      n_queries++;
    end
    cmds_sent++;
  endtask

  task automatic write_bin(input int idx, input int base, input int unsigned day_dh,
                           input int unsigned night_dh);
    dh_cmd_t c;
    c          = rand_cmd();
    c.op       = OP_WRITE;
    c.idx      = 3'(idx);
    c.base     = 16'(base);
    c.day_dh   = 24'(day_dh);
    c.night_dh = 24'(night_dh);
    send_cmd(c);
  endtask

  task automatic query(input int t_day, input int t_night, input int days);
    dh_cmd_t c;
    c         = rand_cmd();
    c.op      = OP_QUERY;
    c.t_day   = 16'(t_day);
    c.t_night = 16'(t_night);
    c.days    = 5'(days);
    send_cmd(c);
  endtask

  // Holds the sender off until every outstanding query has returned.
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_averages.size() != 0) @(posedge clk_i);
  endtask

  // Writes all bins, in a rotated order, with fresh bases and totals.
  task automatic load_table(input load_kind_e kind);
    int b [TABLE_BINS];
    int centre;
    int v;
    int j;
    int rot;
    centre = rand_base() / 2;
    rot    = $urandom_range(TABLE_BINS - 1);
    for (int i = 0; i < TABLE_BINS; i++)
      b[i] = (kind == LOAD_NARROW) ? centre + int'($urandom_range(24)) : rand_base();
    if (kind != LOAD_UNSORTED) begin
      for (int i = 1; i < TABLE_BINS; i++) begin
        v = b[i];
        j = i - 1;
        while (j >= 0 && b[j] > v) begin
          b[j + 1] = b[j];
          j--;
        end
        b[j + 1] = v;
      end
    end
    for (int i = 0; i < TABLE_BINS; i++) begin
      j = (i + rot) % TABLE_BINS;
      write_bin(j, b[j], rand_dh(), rand_dh());
    end
    n_loads++;
    if (kind == LOAD_UNSORTED) n_unsorted++;
  endtask

  // Sorted table spanning the whole temperature range, with totals that both
  // rise and fall, queried at the ends, on bases, inside bins and with the
  // shortest, longest and zero day counts. The whole table is loaded before
  // the first query, since unwritten bins must never be read.
  task automatic test_table_extremes();
    write_bin(0, -32768, 24'hFFFFFF, 0);
    write_bin(1, -1600, 1000000, 7);
    write_bin(2, -160, 50000, 300000);
    write_bin(3, 0, 4000, 300000);
    write_bin(4, 16, 4000, 24'hFFFFFF);
    write_bin(5, 400, 0, 65535);
    write_bin(6, 1200, 123457, 786420);
    write_bin(7, 32767, 24'hFFFFFF, 1);
    query(-32768, 32767, 1);
    query(32767, -32768, 31);
    query(0, 16, 12);
    query(-1599, 1199, 5);
    query(8, -1000, 0);
    query(-32767, 32766, 31);
    query(401, -161, 1);
  endtask

  // Out-of-order bases: the first bin whose upper base reaches the
  // temperature wins, even if a later bin would fit it too.
  task automatic test_unsorted_crossing();
    write_bin(2, 2000, 900000, 12345);
    write_bin(5, -3000, 77, 16000000);
    write_bin(6, -32768, 24'hFFFFFF, 0);
    query(-100, 5000, 3);
    query(10, -32000, 30);
    query(5000, 1999, 2);
  endtask

  // Back-to-back commands with no idling, then a full stop until every
  // result is in before the next query goes out.
  task automatic test_back_to_back_pause();
    sender_idle_pct = 0;
    load_table(LOAD_NARROW);
    query(pick_temp(), pick_temp(), 1);
    query(pick_temp(), pick_temp(), 31);
    query(pick_temp(), pick_temp(), 0);
    wait_drained();
    query(pick_temp(), pick_temp(), rand_days());
  endtask

  // Mostly queries against the current table, interleaved with whole-table
  // reloads and single-bin rewrites, plus the odd full drain.
  task automatic test_random_traffic(input int idle_pct, input int n_cmds);
    int stop_at;
    int r;
    int idx;
    int lo;
    int hi;
    int base;
    sender_idle_pct = idle_pct;
    stop_at = cmds_sent + n_cmds;
    while (cmds_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 2) begin
        wait_drained();
      end else if (r < 6) begin
        r = $urandom_range(99);
        load_table(r < 70 ? LOAD_SORTED : (r < 85 ? LOAD_NARROW : LOAD_UNSORTED));
      end else if (r < 14) begin
        // Single rewrite: usually keeps the order, sometimes breaks it.
        idx = $urandom_range(TABLE_BINS - 1);
        lo  = (idx == 0) ? -32768 : int'(bin_base(idx - 1));
        hi  = (idx == TABLE_BINS - 1) ? 32767 : int'(bin_base(idx + 1));
        if ($urandom_range(1) && lo <= hi) base = lo + int'($urandom_range(hi - lo));
        else base = rand_base();
        write_bin(idx, base, rand_dh(), rand_dh());
      end else begin
        query(pick_temp(), pick_temp(), rand_days());
      end
    end
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_mismatches++;
    end
  endtask

  // Each strobe is matched against the oldest outstanding query.
  always @(posedge clk_i) begin : result_check
    dh_avg_t want;
    if (rst_ni && result_valid_o !== 1'b0) begin
      if (pending_averages.size() == 0) begin
        $display("%0t ns: result strobe mismatch, expected none, got day %0d night %0d err %0d",
                 $time, avg_day_deg_hours_o, avg_night_deg_hours_o, error_o);
        n_mismatches++;
      end else begin
        want = pending_averages.pop_front();
        check_field("day average", want.day_avg, avg_day_deg_hours_o);
        check_field("night average", want.night_avg, avg_night_deg_hours_o);
        check_field("error flag", OUT_W'(want.err), OUT_W'(error_o));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_extremes();
    test_unsorted_crossing();
    test_back_to_back_pause();
    test_random_traffic(25, 590);
    test_random_traffic(59, 580);
    test_random_traffic(0, 580);
    wait_drained();
    // Quiet period to catch any stray strobe after the last result.
    repeat (QUERY_LATENCY + 10) @(posedge clk_i);
    $display("Covered %0d bin writes and %0d queries (%0d with no days, %0d saturating).",
             n_writes, n_queries, n_zero_day, n_saturated);
    $display("Loaded %0d whole tables, %0d of them out of order; %0d mismatches seen.",
             n_loads, n_unsorted, n_mismatches);
    if (n_mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dhti_pkg.sv
rtl/dhti_table.sv
rtl/dhti_div.sv
rtl/dhti_chan.sv
rtl/degree_hour_table_interpolator.sv
tb/sv/tb_top.sv
